// ----- design/ggp_pkg.sv -----
// Grain pool package: payload structs, slot entry layout, op and register codes,
// and the constants for the attack divider. Used by every file in the block.
// No dependencies.
package ggp_pkg;

	localparam int LENGTH_BITS   = 24;
	localparam int MAX_SLOTS_DEF = 16;
	localparam int BASE_W        = 32;
	localparam int ATTACK_W      = 11;
	localparam int SLOT_W        = 4;
	localparam int GRAINS_W      = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 5;

	localparam logic [GRAINS_W-1:0] MAX_GRAINS_RST = GRAINS_W'(16);

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GRAINS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = CFG_IDX_W'(1);

	// attack = length / 40, clamped; done as (length >> 3) / 5
	localparam int ATTACK_DIV    = 40;
	localparam int ATT_PRE_SHIFT = 3;
	localparam int ATT_ODD       = ATTACK_DIV >> ATT_PRE_SHIFT;
	localparam int ATTACK_MIN    = 20;
	localparam int ATTACK_MAX    = 1024;
	localparam int ATT_QW        = LENGTH_BITS - ATT_PRE_SHIFT;
	localparam int ATT_MW        = LENGTH_BITS;
	localparam int ATT_PW        = ATT_QW + ATT_MW;
	localparam int ATT_SHIFT     = LENGTH_BITS;
	localparam int ATT_EW        = (ATT_QW > ATTACK_W) ? ATT_QW : ATTACK_W;
	localparam logic [ATT_MW-1:0] ATT_MULT =
		ATT_MW'(((64'd1 << ATT_SHIFT) + 64'(ATT_ODD) - 64'd1) / 64'(ATT_ODD));

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_TICK   = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [LENGTH_BITS-1:0] grain_length;
		logic [BASE_W-1:0]      base_addr;
		logic [SLOT_W-1:0]      read_slot;
	} cmd_t;

	typedef struct packed {
		logic                   done_ok;
		logic [BASE_W-1:0]      sample_addr;
		logic [ATTACK_W-1:0]    attack_len;
		logic [GRAINS_W-1:0]    grains_live;
	} res_t;

	typedef struct packed {
		logic [BASE_W-1:0]      base;
		logic [LENGTH_BITS-1:0] length;
		logic [LENGTH_BITS-1:0] position;
		logic [ATTACK_W-1:0]    attack;
	} slot_t;

endpackage

// ----- design/granular_grain_pool.sv -----
// Grain pool top level. One item at a time; cmd_ready is high only when idle.
// States after accept: create CDIV, CWR, DONE (refused create: DONE); tick TICK, DONE,
// one slot memory read per cycle in TICK (empty pool: DONE); read READ, DONE; no-op DONE.
// The next item is taken once the result is in the output register.
// Reset (arst_n low, asynchronous): pool empty, max_grains 16, forward mode; no clearing pass.
module granular_grain_pool #(
	parameter int MAX_SLOTS = ggp_pkg::MAX_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  ggp_pkg::cmd_t                  cmd,
	output logic                           res_valid,
	input  logic                           res_ready,
	output ggp_pkg::res_t                  res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ggp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ggp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam int CMPW = ((CW > ggp_pkg::GRAINS_W) ? CW : ggp_pkg::GRAINS_W) + 1;
	localparam int LB   = ggp_pkg::LENGTH_BITS;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_CDIV = 6'b000010,
		ST_CWR  = 6'b000100,
		ST_TICK = 6'b001000,
		ST_READ = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   live_q;
	logic [ggp_pkg::GRAINS_W-1:0]    max_grains_q;
	logic                            reverse_q;
	logic [CW-1:0]                   idx_q;
	logic [CW-1:0]                   kept_q;
	logic                            pend_q;
	logic                            res_valid_q;
	logic [LB-1:0]                   len_q;
	logic [ggp_pkg::BASE_W-1:0]      base_q;
	logic                            rd_ok_q;
	ggp_pkg::res_t                   stage_q;
	ggp_pkg::res_t                   res_q;

	logic                            accept;
	logic                            create_ok;
	logic                            read_ok;
	logic [CMPW-1:0]                 live_c;
	logic [CMPW-1:0]                 max_c;
	logic [CMPW-1:0]                 slot_c;
	logic [CW-1:0]                   live_inc;
	logic [CW-1:0]                   kept_nx;
	logic                            load_out;

	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	ggp_pkg::slot_t                  mem_wdata;
	logic [AW-1:0]                   mem_raddr;
	ggp_pkg::slot_t                  mem_rdata;

	logic [LB-1:0]                   step_pos;
	logic                            step_rev;
	logic [LB-1:0]                   step_next;
	logic                            step_gone;
	logic [ggp_pkg::ATTACK_W-1:0]    attack;

	ggp_slot_mem #(
		.DEPTH (MAX_SLOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ggp_attack u_attack (
		.clk    (clk),
		.len    (len_q),
		.attack (attack)
	);

	ggp_step u_step (
		.pos      (step_pos),
		.length   (mem_rdata.length),
		.reverse  (step_rev),
		.next_pos (step_next),
		.gone     (step_gone)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign load_out  = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	assign live_c   = CMPW'(live_q);
	assign max_c    = CMPW'(max_grains_q);
	assign slot_c   = CMPW'(cmd.read_slot);
	assign live_inc = CW'(live_q + 1'b1);
	assign kept_nx  = CW'(kept_q + CW'(pend_q && !step_gone));

	always_comb begin
		logic cap;
		cap = 1'b0;
		if (live_q != '0) begin
			cap = reverse_q ? ((live_c + CMPW'(1)) >= max_c) : (live_c >= max_c);
		end
		create_ok = (cmd.grain_length != '0) && (live_c < CMPW'(MAX_SLOTS)) && !cap;
	end

	assign read_ok = (slot_c < live_c) && (slot_c < CMPW'(MAX_SLOTS));

	// the stepper also forms length - 1 for a reverse create
	assign step_pos = (state_q == ST_CWR) ? len_q : mem_rdata.position;
	assign step_rev = (state_q == ST_CWR) ? 1'b1 : reverse_q;

	always_comb begin
		mem_raddr = AW'(cmd.read_slot);
		mem_we    = 1'b0;
		mem_waddr = kept_q[AW-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			ST_TICK: begin
				mem_raddr          = idx_q[AW-1:0];
				mem_we             = pend_q && !step_gone;
				mem_wdata.position = step_next;
			end
			ST_CWR: begin
				mem_we             = 1'b1;
				mem_waddr          = live_q[AW-1:0];
				mem_wdata.base     = base_q;
				mem_wdata.length   = len_q;
				mem_wdata.position = reverse_q ? step_next : '0;
				mem_wdata.attack   = attack;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			live_q       <= '0;
			max_grains_q <= ggp_pkg::MAX_GRAINS_RST;
			reverse_q    <= 1'b0;
			idx_q        <= '0;
			kept_q       <= '0;
			pend_q       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ggp_pkg::REG_MAX_GRAINS: max_grains_q <= cfg_data[ggp_pkg::GRAINS_W-1:0];
					ggp_pkg::REG_REVERSE:    reverse_q    <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.op)
							ggp_pkg::OP_CREATE: state_q <= create_ok ? ST_CDIV : ST_DONE;
							ggp_pkg::OP_TICK: begin
								idx_q   <= '0;
								kept_q  <= '0;
								pend_q  <= 1'b0;
								state_q <= (live_q == '0) ? ST_DONE : ST_TICK;
							end
							ggp_pkg::OP_READ: state_q <= ST_READ;
							default:          state_q <= ST_DONE;
						endcase
					end
				end
				ST_CDIV: state_q <= ST_CWR;
				ST_CWR: begin
					live_q  <= live_inc;
					state_q <= ST_DONE;
				end
				ST_TICK: begin
					kept_q <= kept_nx;
					if (idx_q < live_q) begin
						idx_q  <= CW'(idx_q + 1'b1);
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						live_q  <= kept_nx;
						state_q <= ST_DONE;
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					len_q               <= cmd.grain_length;
					base_q              <= cmd.base_addr;
					rd_ok_q             <= read_ok;
					stage_q.done_ok     <= 1'b0;
					stage_q.sample_addr <= '0;
					stage_q.attack_len  <= '0;
					stage_q.grains_live <= ggp_pkg::GRAINS_W'(live_q);
				end
			end
			ST_CWR: begin
				stage_q.done_ok     <= 1'b1;
				stage_q.grains_live <= ggp_pkg::GRAINS_W'(live_inc);
			end
			ST_TICK: begin
				stage_q.grains_live <= ggp_pkg::GRAINS_W'(kept_nx);
			end
			ST_READ: begin
				if (rd_ok_q) begin
					stage_q.done_ok     <= 1'b1;
					stage_q.sample_addr <= mem_rdata.base +
						ggp_pkg::BASE_W'(mem_rdata.position);
					stage_q.attack_len  <= mem_rdata.attack;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			res_q <= stage_q;
		end
	end

endmodule

// ----- design/ggp_slot_mem.sv -----
// Grain slot storage: one write port, one registered read port.
// Depends on ggp_pkg for the slot entry layout.
module ggp_slot_mem #(
	parameter int DEPTH = ggp_pkg::MAX_SLOTS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  ggp_pkg::slot_t  wdata,
	input  logic [AW-1:0]   raddr,
	output ggp_pkg::slot_t  rdata
);

	ggp_pkg::slot_t mem_q [DEPTH];
	ggp_pkg::slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ggp_attack.sv -----
// Attack length of a new grain: length / 40 clamped to 20..1024.
// Reciprocal multiply, product registered; result valid in the cycle after len settles.
// Depends on ggp_pkg for the divider constants.
module ggp_attack (
	input  logic                            clk,
	input  logic [ggp_pkg::LENGTH_BITS-1:0] len,
	output logic [ggp_pkg::ATTACK_W-1:0]    attack
);

	logic [ggp_pkg::ATT_QW-1:0] x;
	logic [ggp_pkg::ATT_PW-1:0] prod_q;
	logic [ggp_pkg::ATT_QW-1:0] quot;
	logic [ggp_pkg::ATT_EW-1:0] quot_ext;

	assign x = len[ggp_pkg::LENGTH_BITS-1:ggp_pkg::ATT_PRE_SHIFT];

	always_ff @(posedge clk) begin
		prod_q <= ggp_pkg::ATT_PW'(x) * ggp_pkg::ATT_PW'(ggp_pkg::ATT_MULT);
	end

	assign quot     = prod_q[ggp_pkg::ATT_PW-1:ggp_pkg::ATT_SHIFT];
	assign quot_ext = ggp_pkg::ATT_EW'(quot);

	always_comb begin
		if (quot_ext < ggp_pkg::ATT_EW'(ggp_pkg::ATTACK_MIN)) begin
			attack = ggp_pkg::ATTACK_W'(ggp_pkg::ATTACK_MIN);
		end else if (quot_ext > ggp_pkg::ATT_EW'(ggp_pkg::ATTACK_MAX)) begin
			attack = ggp_pkg::ATTACK_W'(ggp_pkg::ATTACK_MAX);
		end else begin
			attack = quot_ext[ggp_pkg::ATTACK_W-1:0];
		end
	end

endmodule

// ----- design/ggp_step.sv -----
// Shared position stepper: one adder steps a play position by +1 or -1 and
// flags a grain that runs past its end. Depends on ggp_pkg for widths.
module ggp_step (
	input  logic [ggp_pkg::LENGTH_BITS-1:0] pos,
	input  logic [ggp_pkg::LENGTH_BITS-1:0] length,
	input  logic                            reverse,
	output logic [ggp_pkg::LENGTH_BITS-1:0] next_pos,
	output logic                            gone
);

	// all-ones addend is -1 mod 2^LENGTH_BITS
	assign next_pos = pos + (reverse ? {ggp_pkg::LENGTH_BITS{1'b1}}
	                                 : ggp_pkg::LENGTH_BITS'(1));
	assign gone     = reverse ? (pos == '0) : (next_pos == length);

endmodule
